// ===== src/sgdm_pkg.sv =====
// Shared widths, register codes, types and arithmetic helpers for the SGD momentum update.
package sgdm_pkg;

  localparam int IDX_W    = 16;
  localparam int DATA_W   = 32;
  localparam int COEF_W   = 25;
  localparam int FRAC_W   = 24;
  localparam int PROD_W   = DATA_W + COEF_W;
  localparam int WIDE_W   = 36;
  localparam int IDX_SPAN = 1 << IDX_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [COEF_W-1:0] LR_RESET  = 25'd167772;
  localparam logic [COEF_W-1:0] MOM_RESET = 25'd15099494;
  localparam logic [COEF_W-1:0] DEC_RESET = 25'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_MOMENTUM      = 2'd1,
    CFG_DECAY         = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

  // velocity store write request
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         addr;
    logic signed [DATA_W-1:0] data;
  } vel_wr_t;

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] a);
    logic [DATA_W-1:0] u;
    u = a;
    return u[DATA_W-1] ? (~u + 32'd1) : u;
  endfunction

  function automatic logic [PROD_W-1:0] mul_mag(input logic [DATA_W-1:0] m,
                                                input logic [COEF_W-1:0] c);
    return {{COEF_W{1'b0}}, m} * {{DATA_W{1'b0}}, c};
  endfunction

  // round to nearest, ties away from zero, then restore sign
  function automatic logic signed [WIDE_W-1:0] rnd_q(input logic [PROD_W-1:0] p,
                                                     input logic neg);
    logic [PROD_W:0]   s;
    logic [WIDE_W-1:0] q;
    s = {1'b0, p} + ((PROD_W+1)'(1) << (FRAC_W - 1));
    q = WIDE_W'(s[PROD_W:FRAC_W]);
    return signed'(neg ? (~q + 36'd1) : q);
  endfunction

  function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] x);
    sat_t r;
    r.clip = 1'b0;
    r.val  = x[DATA_W-1:0];
    if (x > 36'sh07FFFFFFF) begin
      r.clip = 1'b1;
      r.val  = 32'sh7FFFFFFF;
    end else if (x < 36'shF80000000) begin
      r.clip = 1'b1;
      r.val  = 32'sh80000000;
    end
    return r;
  endfunction

endpackage

// ===== src/sgd_momentum_update.sv =====
// Top level of the streaming SGD momentum optimizer (Q8.24 weights, Q1.24 coefficients).
//
// Usage:
//  - Input channel in_*: one parameter per transfer (index, weight, gradient, decay flag).
//    A transfer happens when in_valid is high and in_stall is low.
//  - Output channel out_*: exactly one result per input, in order, same transfer rule.
//  - cfg_*: register writes (0 learning rate, 1 momentum, 2 decay); cfg_ready is always
//    high, index 3 is ignored. Write only while the pipeline is empty.
//  - Each result passes through stages 1 to 5 and then the output register.
//  - Throughput: up to one item per cycle. An item with the index of the immediately
//    preceding transfer waits for a bubble: the velocity loop (momentum multiply, then
//    subtract/saturate) spans two stages and is closed by a bypass from stage 5.
//  - Reset: coefficients return to defaults; the MEM_DEPTH (65536 by default) velocity
//    entries are swept to zero, one entry per cycle; in_stall stays high then.
//  - Receiver stall: the whole pipeline freezes while out_valid is high and out_stall is
//    high; nothing is lost or repeated, and in_stall rises with it.
//  - Stages: 1 decay product, 2 gradient add/sat + memory read, 3 bypass + two products,
//    4 round/subtract/sat + memory write, 5 weight add/sat into the output register.
module sgd_momentum_update import sgdm_pkg::*; #(
  parameter int PARAM_COUNT = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [IDX_W-1:0]            in_param_index,
  input  logic signed [DATA_W-1:0]    in_weight_in,
  input  logic signed [DATA_W-1:0]    in_gradient_in,
  input  logic                        in_apply_decay,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [IDX_W-1:0]            out_result_index,
  output logic signed [DATA_W-1:0]    out_weight_out,
  output logic                        out_saturated,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COEF_W-1:0]           cfg_data
);

  localparam int MEM_DEPTH = (PARAM_COUNT > IDX_SPAN) ? IDX_SPAN : PARAM_COUNT;
  localparam logic [COEF_W-1:0] PCNT = COEF_W'(PARAM_COUNT);

  // coefficients
  logic [COEF_W-1:0] lr_r, mom_r, dec_r;

  // pipeline control
  logic adv, hazard, busy, in_acc;

  // stage 1
  logic                     s1_valid_r, s1_inr_r, s1_dec_r, s1_wneg_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic signed [DATA_W-1:0] s1_w_r, s1_g_r;
  logic [PROD_W-1:0]        s1_dprod_r;
  logic                     s1_inr_nxt;

  // stage 2
  logic                     s2_valid_r, s2_inr_r, s2_clip_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic signed [DATA_W-1:0] s2_w_r, s2_gp_r;
  sat_t                     gp_nxt;

  // stage 3
  logic                     s3_valid_r, s3_inr_r, s3_clip_r;
  logic [IDX_W-1:0]         s3_idx_r;
  logic signed [DATA_W-1:0] s3_w_r, s3_gp_r;
  logic signed [DATA_W-1:0] vold, rd_data;

  // stage 4
  logic                     s4_valid_r, s4_inr_r, s4_clip_r, s4_mneg_r, s4_lneg_r;
  logic [IDX_W-1:0]         s4_idx_r;
  logic signed [DATA_W-1:0] s4_w_r;
  logic [PROD_W-1:0]        s4_mprod_r, s4_lprod_r;
  sat_t                     v_nxt;
  vel_wr_t                  vel_wr;

  // stage 5
  logic                     s5_valid_r, s5_inr_r, s5_clip_r;
  logic [IDX_W-1:0]         s5_idx_r;
  logic signed [DATA_W-1:0] s5_w_r, s5_v_r;
  sat_t                     wn_nxt;

  // output register
  logic                     out_valid_r, out_sat_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic signed [DATA_W-1:0] out_w_r;

  // ---------------------------------------------------------------- control
  assign adv       = ~out_valid_r | ~out_stall;
  // same index back to back would need a velocity still inside stage 4
  assign hazard    = s1_valid_r & (s1_idx_r == in_param_index);
  assign in_stall  = ~adv | busy | hazard;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= LR_RESET;
      mom_r <= MOM_RESET;
      dec_r <= DEC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEARNING_RATE: lr_r  <= cfg_data;
        CFG_MOMENTUM:      mom_r <= cfg_data;
        CFG_DECAY:         dec_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  assign s1_inr_nxt = {{(COEF_W-IDX_W){1'b0}}, in_param_index} < PCNT;

  assign gp_nxt = s1_dec_r
                ? sat_wide(WIDE_W'(s1_g_r) + rnd_q(s1_dprod_r, s1_wneg_r))
                : sat_t'{clip: 1'b0, val: s1_g_r};

  // bypass the velocity written on the same edge as this item's read
  always_comb begin
    if (!s3_inr_r) begin
      vold = '0;
    end else if (s5_valid_r && s5_inr_r && (s5_idx_r == s3_idx_r)) begin
      vold = s5_v_r;
    end else begin
      vold = rd_data;
    end
  end

  assign v_nxt  = sat_wide(rnd_q(s4_mprod_r, s4_mneg_r) - rnd_q(s4_lprod_r, s4_lneg_r));
  assign wn_nxt = sat_wide(WIDE_W'(s5_w_r) + WIDE_W'(s5_v_r));

  always_comb begin
    vel_wr.en   = adv & s4_valid_r & s4_inr_r;
    vel_wr.addr = s4_idx_r;
    vel_wr.data = v_nxt.val;
  end

  sgdm_vel_store #(
    .DEPTH (MEM_DEPTH)
  ) u_vel_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (adv),
    .rd_addr (s2_idx_r),
    .rd_data (rd_data),
    .wr      (vel_wr),
    .busy    (busy)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_acc;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  // payload, frozen with the valid bits
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r   <= in_param_index;
      s1_w_r     <= in_weight_in;
      s1_g_r     <= in_gradient_in;
      s1_dec_r   <= in_apply_decay;
      s1_inr_r   <= s1_inr_nxt;
      s1_wneg_r  <= in_weight_in[DATA_W-1];
      s1_dprod_r <= mul_mag(mag32(in_weight_in), dec_r);

      s2_idx_r   <= s1_idx_r;
      s2_w_r     <= s1_w_r;
      s2_inr_r   <= s1_inr_r;
      s2_gp_r    <= gp_nxt.val;
      s2_clip_r  <= gp_nxt.clip;

      s3_idx_r   <= s2_idx_r;
      s3_w_r     <= s2_w_r;
      s3_inr_r   <= s2_inr_r;
      s3_gp_r    <= s2_gp_r;
      s3_clip_r  <= s2_clip_r;

      s4_idx_r   <= s3_idx_r;
      s4_w_r     <= s3_w_r;
      s4_inr_r   <= s3_inr_r;
      s4_clip_r  <= s3_clip_r;
      s4_mneg_r  <= vold[DATA_W-1];
      s4_mprod_r <= mul_mag(mag32(vold), mom_r);
      s4_lneg_r  <= s3_gp_r[DATA_W-1];
      s4_lprod_r <= mul_mag(mag32(s3_gp_r), lr_r);

      s5_idx_r   <= s4_idx_r;
      s5_w_r     <= s4_w_r;
      s5_inr_r   <= s4_inr_r;
      s5_v_r     <= v_nxt.val;
      s5_clip_r  <= s4_clip_r | v_nxt.clip;

      out_idx_r  <= s5_idx_r;
      out_w_r    <= wn_nxt.val;
      out_sat_r  <= s5_clip_r | wn_nxt.clip;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_weight_out   = out_w_r;
  assign out_saturated    = out_sat_r;

endmodule

// ===== src/sgdm_vel_store.sv =====
// Velocity memory: one write port, one registered read port, zero sweep after reset.
module sgdm_vel_store import sgdm_pkg::*; #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [IDX_W-1:0]         rd_addr,
  output logic signed [DATA_W-1:0] rd_data,
  input  vel_wr_t                  wr,
  output logic                     busy
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]        clr_cnt_r;
  logic                     busy_r;
  logic                     we;
  logic [ADDR_W-1:0]        wa;
  logic signed [DATA_W-1:0] wd;

  // sweep owns the port until done; no items are taken meanwhile
  always_comb begin
    we = busy_r | wr.en;
    wa = busy_r ? clr_cnt_r : wr.addr[ADDR_W-1:0];
    wd = busy_r ? '0 : wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// ===== tb/sv/sgdm_update_checker.sv =====
// Checker for the SGD momentum update: predicts every updated weight and scores the result stream.
module sgdm_update_checker import sgdm_pkg::*; #(
  parameter int PARAM_COUNT = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [IDX_W-1:0]         in_param_index,
  input  logic signed [DATA_W-1:0] in_weight_in,
  input  logic signed [DATA_W-1:0] in_gradient_in,
  input  logic                     in_apply_decay,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [IDX_W-1:0]         out_result_index,
  input  logic signed [DATA_W-1:0] out_weight_out,
  input  logic                     out_saturated,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [COEF_W-1:0]        cfg_data,
  output int                       fail_count,
  output int                       pending,
  output int                       checked
);

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] weight;
    logic                     sat;
  } weight_update_t;

  logic [COEF_W-1:0]        lr_coef;
  logic [COEF_W-1:0]        mom_coef;
  logic [COEF_W-1:0]        decay_coef;
  logic signed [DATA_W-1:0] velocity [IDX_SPAN];
  weight_update_t           updates_due [$];
  int                       errs;
  int                       done;

  // Q8.24 times unsigned Q1.24, rounded to nearest with ties away from zero
  function automatic longint scale_round(input longint a, input logic [COEF_W-1:0] c);
    longint m;
    longint q;
    m = (a < 0) ? -a : a;
    q = (m * longint'(c) + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    return (a < 0) ? -q : q;
  endfunction

  function automatic longint clamp32(input longint x, inout logic hit);
    if (x > SAT_HI) begin
      hit = 1'b1;
      return SAT_HI;
    end
    if (x < SAT_LO) begin
      hit = 1'b1;
      return SAT_LO;
    end
    return x;
  endfunction

  // one optimizer step; also updates the velocity entry
  function automatic weight_update_t momentum_step(input logic [IDX_W-1:0] idx,
                                                   input logic signed [DATA_W-1:0] w,
                                                   input logic signed [DATA_W-1:0] g,
                                                   input logic use_decay);
    weight_update_t r;
    longint         w64;
    longint         grad;
    longint         v_prev;
    longint         v;
    longint         wn;
    logic           hit;
    hit  = 1'b0;
    w64  = w;
    grad = g;
    if (use_decay) grad = clamp32(grad + scale_round(w64, decay_coef), hit);
    v_prev = (idx < PARAM_COUNT) ? longint'(velocity[idx]) : 64'sd0;
    v = clamp32(scale_round(v_prev, mom_coef) - scale_round(grad, lr_coef), hit);
    if (idx < PARAM_COUNT) velocity[idx] = v[DATA_W-1:0];
    wn = clamp32(w64 + v, hit);
    r.idx    = idx;
    r.weight = wn[DATA_W-1:0];
    r.sat    = hit;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    weight_update_t want;
    if (!rst_n) begin
      lr_coef    = LR_RESET;
      mom_coef   = MOM_RESET;
      decay_coef = DEC_RESET;
      foreach (velocity[i]) velocity[i] = '0;
      updates_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEARNING_RATE: lr_coef = cfg_data;
          CFG_MOMENTUM:      mom_coef = cfg_data;
          CFG_DECAY:         decay_coef = cfg_data;
          default:           ;
        endcase
      end
      // results first: a result at this edge belongs to an older transfer
      if (out_valid && !out_stall) begin
        if (updates_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, index %0d weight %0d saturated %0b",
                   $time, out_result_index, out_weight_out, out_saturated);
        end else begin
          want = updates_due.pop_front();
          done++;
          if (out_result_index !== want.idx) begin
            errs++;
            $display("%0t: result_index expected %0d got %0d",
                     $time, want.idx, out_result_index);
          end
          if (out_weight_out !== want.weight) begin
            errs++;
            $display("%0t: weight_out (index %0d) expected %0d got %0d",
                     $time, want.idx, want.weight, out_weight_out);
          end
          if (out_saturated !== want.sat) begin
            errs++;
            $display("%0t: saturated (index %0d) expected %0b got %0b",
                     $time, want.idx, want.sat, out_saturated);
          end
        end
      end
      if (in_valid && !in_stall)
        updates_due.push_back(momentum_step(in_param_index, in_weight_in,
                                            in_gradient_in, in_apply_decay));
    end
    fail_count <= errs;
    pending    <= updates_due.size();
    checked    <= done;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top for the SGD momentum update: stimulus, coefficient phases, watchdog and verdict.
module testbench;
  import sgdm_pkg::*;

  // The velocity sweep after reset holds in_stall while it clears all 65536 entries,
  // so the watchdog limit sits well above it.
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 108;
  localparam int DRAIN_CYCLES   = 10;   // pipeline is 5 deep

  localparam logic signed [DATA_W-1:0] W_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] W_MIN = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] ONE_Q = 32'sh01000000;
  localparam logic [COEF_W-1:0] COEF_ONE  = 25'd16777216;
  localparam logic [COEF_W-1:0] COEF_HALF = 25'd8388608;
  localparam logic [COEF_W-1:0] COEF_TOP  = 25'h1FFFFFF;   // just under 2.0
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;       // unmapped, must be ignored

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [IDX_W-1:0]         in_param_index = '0;
  logic signed [DATA_W-1:0] in_weight_in = '0;
  logic signed [DATA_W-1:0] in_gradient_in = '0;
  logic                     in_apply_decay = 1'b0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IDX_W-1:0]         out_result_index;
  logic signed [DATA_W-1:0] out_weight_out;
  logic                     out_saturated;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [COEF_W-1:0]        cfg_data = '0;

  logic             steady = 1'b0;   // high: neither side idles
  logic [IDX_W-1:0] last_idx = '0;
  int               sent = 0;
  int               settings = 0;
  int               idle_cycles = 0;
  int               fail_count;
  int               pending;
  int               checked;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sgd_momentum_update dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_param_index   (in_param_index),
    .in_weight_in     (in_weight_in),
    .in_gradient_in   (in_gradient_in),
    .in_apply_decay   (in_apply_decay),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_weight_out   (out_weight_out),
    .out_saturated    (out_saturated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  sgdm_update_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_param_index   (in_param_index),
    .in_weight_in     (in_weight_in),
    .in_gradient_in   (in_gradient_in),
    .in_apply_decay   (in_apply_decay),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_weight_out   (out_weight_out),
    .out_saturated    (out_saturated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  // Receiver back-pressure: about 30% of cycles, none in the steady phase.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 30);
  end

  // Watchdog: cycles in a row with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // One parameter transfer. Handshake is sampled at the falling edge, where
  // in_stall is settled, and the transfer lands on the next rising edge.
  // Returns at that edge with in_valid still high.
  task automatic push_update(input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] w,
                             input logic signed [DATA_W-1:0] g,
                             input logic use_decay);
    while (!steady && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_param_index <= idx;
    in_weight_in   <= w;
    in_gradient_in <= g;
    in_apply_decay <= use_decay;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent++;
    last_idx = idx;
  endtask

  // Register write; leaves cfg_valid high so back-to-back writes need no toggle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // New coefficient set: stop the stream, let the pipeline drain, then write
  // all three registers plus the unmapped index.
  task automatic set_coeffs(input logic [COEF_W-1:0] lr,
                            input logic [COEF_W-1:0] mom,
                            input logic [COEF_W-1:0] dec);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    write_reg(CFG_LEARNING_RATE, lr);
    write_reg(CFG_MOMENTUM, mom);
    write_reg(CFG_DECAY, dec);
    write_reg(CFG_SPARE, COEF_W'($urandom));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic signed [DATA_W-1:0] random_q824();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;  // within +-2.0
      5, 6, 7:       return $urandom;
      8:             return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      default: begin
        case ($urandom_range(0, 3))
          0:       return W_MAX;
          1:       return W_MIN;
          2:       return '0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // Index mix: repeats of the previous index hit the velocity bypass, a small
  // hot set lets velocities build up, the rest spreads over the whole store.
  task automatic send_random_update();
    logic [IDX_W-1:0] idx;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)
      idx = last_idx;
    else if (pick < 65) begin
      case ($urandom_range(0, 7))
        0:       idx = 16'd0;
        1:       idx = 16'd1;
        2:       idx = 16'd2;
        3:       idx = 16'd3;
        4:       idx = 16'd100;
        5:       idx = 16'd4095;
        6:       idx = 16'd32768;
        default: idx = 16'hFFFF;
      endcase
    end else
      idx = IDX_W'($urandom);
    push_update(idx, random_q824(), random_q824(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset coefficients: zero item, extremes, same index back to back.
    push_update(16'd0, 32'sd0, 32'sd0, 1'b0);
    push_update(16'hFFFF, W_MAX, W_MIN, 1'b1);
    push_update(16'hFFFF, W_MIN, W_MAX, 1'b0);
    push_update(16'hFFFF, W_MIN, W_MIN, 1'b1);
    push_update(16'd1, -32'sd1, 32'sd1, 1'b1);
    push_update(16'd1, 32'sd1, -32'sd1, 1'b0);

    // Half coefficients: odd values give exact half-LSB products (ties away from zero).
    set_coeffs(COEF_HALF, COEF_HALF, COEF_HALF);
    push_update(16'd2, 32'sd1, 32'sd1, 1'b1);
    push_update(16'd3, -32'sd1, -32'sd1, 1'b1);
    push_update(16'd3, 32'sd3, 32'sd1, 1'b0);
    push_update(16'd2, 32'sd5, -32'sd3, 1'b1);

    // Gains at and above one: clipping of gradient, velocity and weight.
    set_coeffs(COEF_ONE, COEF_TOP, COEF_TOP);
    push_update(16'd5, W_MAX, W_MAX, 1'b1);
    push_update(16'd5, W_MIN, W_MIN, 1'b1);
    push_update(16'd6, W_MAX, W_MIN, 1'b0);
    push_update(16'd6, 32'sd0, W_MIN, 1'b0);
    push_update(16'd7, ONE_Q, -ONE_Q, 1'b1);
    push_update(16'd7, -ONE_Q, ONE_Q, 1'b1);

    // All coefficients zero: velocity collapses, weight passes through.
    set_coeffs('0, '0, '0);
    push_update(16'd5, W_MAX, W_MIN, 1'b1);
    push_update(16'd0, W_MIN, W_MAX, 1'b1);

    // Random phases, each under its own coefficient set; phase 3 runs without idling.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       set_coeffs(LR_RESET, MOM_RESET, DEC_RESET);
        1:       set_coeffs(COEF_ONE, COEF_ONE, COEF_ONE);
        4:       set_coeffs(COEF_W'($urandom_range(0, COEF_TOP)),
                            COEF_W'($urandom_range(0, COEF_TOP)),
                            COEF_W'($urandom_range(0, COEF_TOP)));
        default: set_coeffs(COEF_W'($urandom_range(0, 1 << 22)),
                            COEF_W'($urandom_range(1 << 23, COEF_ONE)),
                            COEF_W'($urandom_range(0, 1 << 20)));
      endcase
      steady <= (phase == 3);
      repeat (PHASE_ITEMS) send_random_update();
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d parameter updates under %0d coefficient settings plus reset defaults",
             sent, settings);
    $display("%0d results compared against predicted weights and clip flags", checked);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sgdm_pkg.sv
src/sgdm_vel_store.sv
src/sgd_momentum_update.sv
tb/sv/sgdm_update_checker.sv
tb/sv/testbench.sv
